// ----- rtl/msta_pkg.sv -----
package msta_pkg;

  // Report kinds carried in the low bits of s_tuser
  typedef enum logic [1:0] {
    FUNC_TH    = 2'd0,
    FUNC_GYRO  = 2'd1,
    FUNC_DIST  = 2'd2,
    FUNC_KNOB  = 2'd3
  } func_t;

  // Configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_HOT    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DRY    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_NEAR   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KNOB   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MOTION = 3'd4;
  localparam int CfgDataW = 11;

  // Reset values and allowed ranges of the limits
  localparam logic [6:0]  HOT_RESET    = 7'd32;
  localparam logic [6:0]  DRY_RESET    = 7'd30;
  localparam logic [10:0] NEAR_RESET   = 11'd120;
  localparam logic [6:0]  KNOB_RESET   = 7'd80;
  localparam logic [10:0] MOTION_RESET = 11'd100;
  localparam logic [6:0]  HOT_MAX      = 7'd80;
  localparam logic [6:0]  PCT_MAX      = 7'd100;
  localparam logic [10:0] NEAR_MIN     = 11'd10;
  localparam logic [10:0] NEAR_MAX     = 11'd2000;
  localparam logic [10:0] MOTION_MIN   = 11'd1;
  localparam logic [10:0] MOTION_MAX   = 11'd2000;

  // Flag bit positions
  localparam int ALERT_HOT    = 0;
  localparam int ALERT_DRY    = 1;
  localparam int ALERT_NEAR   = 2;
  localparam int ALERT_KNOB   = 3;
  localparam int ALERT_MOTION = 4;
  localparam int FAIL_TH      = 0;
  localparam int FAIL_GYRO    = 1;
  localparam int FAIL_DIST    = 2;
  localparam int FAIL_KNOB    = 3;

  localparam int InDataW  = 88;
  localparam int InUserW  = 4;
  localparam int OutDataW = 16;

  typedef struct packed {
    logic [6:0]  hot_limit_celsius;
    logic [6:0]  dry_limit_percent;
    logic [10:0] near_limit_mm;
    logic [6:0]  knob_high_percent;
    logic [10:0] motion_limit_dps;
  } limits_t;

  typedef struct packed {
    func_t              func;
    logic               report_valid;
    logic               range_ok;
    logic [7:0]         temperature_c;
    logic [7:0]         humidity_pct;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic [15:0]        dist_mm;
    logic [7:0]         knob_percent;
  } report_t;

  typedef struct packed {
    logic [4:0] alert_flags;
    logic [3:0] fail_flags;
  } flags_t;

  // Magnitude of a signed rate, most negative value saturates at 32767
  function automatic logic [14:0] rate_mag(input logic signed [15:0] rate);
    logic [15:0] neg;
    neg = 16'(-rate);
    if (!rate[15]) begin
      rate_mag = rate[14:0];
    end else if (neg[15]) begin
      rate_mag = 15'h7FFF;
    end else begin
      rate_mag = neg[14:0];
    end
  endfunction

endpackage

// ----- rtl/msta_cfg.sv -----
module msta_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [msta_pkg::CfgIdxW-1:0]   wr_index,
  input  logic [msta_pkg::CfgDataW-1:0]  wr_data,
  output msta_pkg::limits_t              limits
);
  import msta_pkg::*;

  logic [6:0]  val7;
  logic [10:0] val11;

  assign val7  = wr_data[6:0];
  assign val11 = wr_data;

  // Hold each limit; drop writes whose value falls outside its range
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.hot_limit_celsius <= HOT_RESET;
      limits.dry_limit_percent <= DRY_RESET;
      limits.near_limit_mm     <= NEAR_RESET;
      limits.knob_high_percent <= KNOB_RESET;
      limits.motion_limit_dps  <= MOTION_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_HOT: begin
          if (val7 <= HOT_MAX) limits.hot_limit_celsius <= val7;
        end
        REG_DRY: begin
          if (val7 <= PCT_MAX) limits.dry_limit_percent <= val7;
        end
        REG_NEAR: begin
          if (val11 >= NEAR_MIN && val11 <= NEAR_MAX) limits.near_limit_mm <= val11;
        end
        REG_KNOB: begin
          if (val7 <= PCT_MAX) limits.knob_high_percent <= val7;
        end
        REG_MOTION: begin
          if (val11 >= MOTION_MIN && val11 <= MOTION_MAX) limits.motion_limit_dps <= val11;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/msta_eval.sv -----
module msta_eval (
  input  msta_pkg::report_t  report,
  input  msta_pkg::limits_t  limits,
  input  msta_pkg::flags_t   flags_cur,
  output msta_pkg::flags_t   flags_next
);
  import msta_pkg::*;

  logic [14:0] mag_x;
  logic [14:0] mag_y;
  logic [14:0] mag_z;
  logic        motion;
  logic        vld;

  assign vld    = report.report_valid;
  assign mag_x  = rate_mag(report.rate_x);
  assign mag_y  = rate_mag(report.rate_y);
  assign mag_z  = rate_mag(report.rate_z);
  assign motion = (mag_x > 15'(limits.motion_limit_dps)) ||
                  (mag_y > 15'(limits.motion_limit_dps)) ||
                  (mag_z > 15'(limits.motion_limit_dps));

  // Update only the flags of the reported sensor kind
  always_comb begin
    flags_next = flags_cur;
    unique case (report.func)
      FUNC_TH: begin
        flags_next.fail_flags[FAIL_TH]    = !vld;
        flags_next.alert_flags[ALERT_HOT] =
          vld && (report.temperature_c >= 8'(limits.hot_limit_celsius));
        flags_next.alert_flags[ALERT_DRY] =
          vld && (report.humidity_pct <= 8'(limits.dry_limit_percent));
      end
      FUNC_GYRO: begin
        flags_next.fail_flags[FAIL_GYRO]     = !vld;
        flags_next.alert_flags[ALERT_MOTION] = vld && motion;
      end
      FUNC_DIST: begin
        flags_next.fail_flags[FAIL_DIST]   = !vld;
        flags_next.alert_flags[ALERT_NEAR] = vld && report.range_ok &&
          (report.dist_mm < 16'(limits.near_limit_mm));
      end
      FUNC_KNOB: begin
        flags_next.fail_flags[FAIL_KNOB]   = !vld;
        flags_next.alert_flags[ALERT_KNOB] =
          vld && (report.knob_percent >= 8'(limits.knob_high_percent));
      end
    endcase
  end

endmodule

// ----- rtl/multisensor_threshold_alert_monitor.sv -----
// Channel   Direction  Content
// s_axis    in         tdata: sensor readings, tuser: report kind and status bits
// m_axis    out        tdata: alert and failure flags after the report
// cfg       in         limit register write (index, value)
//
// One report per cycle sustained while m_tready stays high; a report passes
// through the input register, then flag evaluation into the result register.
// The flag registers update as a report moves into the result register.
// Reset (rst, synchronous) empties both stages, clears all flags and loads
// the default limits. A stalled result holds while one more report waits
// in the input register; cfg_ready is always high.
module multisensor_threshold_alert_monitor (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [7:0] temperature_c, [15:8] humidity_pct, [31:16] rate_x, [47:32] rate_y,
  // [63:48] rate_z, [79:64] dist_mm, [87:80] knob_percent
  input  logic [msta_pkg::InDataW-1:0]       s_tdata,
  // [1:0] func, [2] report_valid, [3] range_ok
  input  logic [msta_pkg::InUserW-1:0]       s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [4:0] alert_flags, [8:5] fail_flags, [15:9] zero
  output logic [msta_pkg::OutDataW-1:0]      m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [msta_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [msta_pkg::CfgDataW-1:0]      cfg_data
);
  import msta_pkg::*;

  limits_t limits;
  report_t in_report;
  logic    in_valid;
  flags_t  flags;
  flags_t  flags_next;
  flags_t  result;
  logic    advance;

  assign cfg_ready = 1'b1;

  msta_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .limits   (limits)
  );

  msta_eval u_eval (
    .report     (in_report),
    .limits     (limits),
    .flags_cur  (flags),
    .flags_next (flags_next)
  );

  // Move the input stage forward when the result register is free
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Input stage payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_report.func          <= func_t'(s_tuser[1:0]);
      in_report.report_valid  <= s_tuser[2];
      in_report.range_ok      <= s_tuser[3];
      in_report.temperature_c <= s_tdata[7:0];
      in_report.humidity_pct  <= s_tdata[15:8];
      in_report.rate_x        <= s_tdata[31:16];
      in_report.rate_y        <= s_tdata[47:32];
      in_report.rate_z        <= s_tdata[63:48];
      in_report.dist_mm       <= s_tdata[79:64];
      in_report.knob_percent  <= s_tdata[87:80];
    end
  end

  // Flag state advances with each evaluated report
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (advance) begin
      flags <= flags_next;
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      result <= flags_next;
    end
  end

  assign m_tdata = {7'd0, result.fail_flags, result.alert_flags};

endmodule

// ----- rtl/msta_checker.sv -----
module msta_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [msta_pkg::OutDataW-1:0]      m_tdata
);

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result holds its flags
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Padding above the flags stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:9] == 7'd0)
    else $error("nonzero padding in result");

  // Input side never stalls while the output side is draining
  a_ready_on_drain: assert property (@(posedge clk) disable iff (rst)
    (m_tready || !m_tvalid) |-> s_tready)
    else $error("input stalled with output free");

  // An accepted report is followed by a valid result on the output
  a_accept_reaches_output: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> ##1 m_tvalid)
    else $error("accepted report produced no result");

endmodule

bind multisensor_threshold_alert_monitor msta_checker u_msta_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
